/* sv/ccnb_element_encoder_defines.svh */
// Assertion macros for the CCNb element encoder.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
// Defining ASSERT_OFF removes every assertion.
`ifndef CCNB_ELEMENT_ENCODER_DEFINES_SVH
`define CCNB_ELEMENT_ENCODER_DEFINES_SVH

`ifndef ASSERT_OFF

// Checked on every clock edge outside of reset.
`define CCNB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Checked on every clock edge, reset included.
`define CCNB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) \
      else $error(msg);

`else

`define CCNB_ASSERT(lbl, clk, rst, prop, msg)
`define CCNB_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* sv/ccnb_pkg.sv */
// Shared types and constants of the CCNb element encoder.
// No dependencies; used by the encoder and its testbench.
`default_nettype none

package ccnb_pkg;

   // Command codes of an input item.
   localparam logic [2:0] CMD_TAG_HDR  = 3'd0;
   localparam logic [2:0] CMD_BLOB_HDR = 3'd1;
   localparam logic [2:0] CMD_DATA     = 3'd2;
   localparam logic [2:0] CMD_END      = 3'd3;
   localparam logic [2:0] CMD_INT_ELEM = 3'd4;

   localparam logic [2:0] BLOB_TYPE_RESET = 3'd5;
   localparam logic [7:0] END_BYTE        = 8'h00;

   typedef struct packed {
      logic [2:0]  command;
      logic [31:0] number;
      logic [2:0]  tag_type;
      logic [31:0] int_value;
      logic [2:0]  byte_count;
      logic [7:0]  data_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } rsp_payload_type;

endpackage

`default_nettype wire

/* sv/ccnb_chan_if.sv */
// Valid/ready channel carrying one payload item per handshake.
// The payload type is a parameter; the instances take their types from ccnb_pkg.
`default_nettype none

interface ccnb_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* sv/ccnb_element_encoder.sv */
// CCNb element encoder: a command in, its wire bytes out, one byte per cycle unless stalled.
// An accepted item is stored, and its first byte enters the output register once it is free.
// Throughput: one byte per cycle unless stalled; an item holds the sequencer until all its
//   bytes, 1 to MAX_INT_BYTES + 7 (11 at the default), leave by the single output byte lane.
// Unused command codes are accepted and dropped; they emit nothing.
// Reset (synchronous): both stages empty, blob type code back to 5.
`default_nettype none
`include "ccnb_element_encoder_defines.svh"

module ccnb_element_encoder
   import ccnb_pkg::*;
#(
   parameter int MAX_INT_BYTES = 4
) (
   input  wire logic       clock,
   input  wire logic       reset,
   ccnb_chan_if.sink       req_chan,
   ccnb_chan_if.source     rsp_chan,
   input  wire logic       csr_write_enable,
   input  wire logic [2:0] csr_write_data
);

   // Width of a clamped value byte count (1 .. MAX_INT_BYTES).
   localparam int NB_W = $clog2(MAX_INT_BYTES + 1);
   // Width of the byte index within one item; the longest item has MAX_INT_BYTES + 7 bytes.
   localparam int IDX_W = $clog2(MAX_INT_BYTES + 8);
   localparam logic [NB_W-1:0] NB_MAX = NB_W'(MAX_INT_BYTES);

   // ---------------------------------------------------------------------------------------
   // Configuration register. The user must write it only while the block is idle (the block
   // does not enforce this), so the sequencer may read it while an item is being emitted.
   // ---------------------------------------------------------------------------------------
   logic [2:0] blob_type_ff, blob_type_in;

   always_comb begin
      blob_type_in = blob_type_ff;
      if (csr_write_enable) begin
         blob_type_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blob_type_ff <= BLOB_TYPE_RESET;
      end else begin
         blob_type_ff <= blob_type_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Input side. Two small figures are computed while the item is taken in and stored with
   // it: the count of 7-bit high groups of the header number up to the highest nonzero one,
   // and the value byte count of an integer element after the automatic length and the clamp.
   // ---------------------------------------------------------------------------------------
   req_payload_type item_ff, item_in;
   logic            hold_valid_ff, hold_valid_in;
   logic [2:0]      grp_cnt_ff, grp_cnt_in;
   logic [NB_W-1:0] nb_ff, nb_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   logic            req_ready;
   logic            req_accept;
   logic            cmd_known;
   logic [27:0]     req_rest;
   logic [2:0]      hi_len;
   logic [3:0]      req_len;

   assign req_accept = req_chan.valid && req_ready;
   assign cmd_known  = (req_chan.payload.command <= CMD_INT_ELEM);
   assign req_rest   = req_chan.payload.number[31:4];

   always_comb begin
      // Header groups are emitted from the highest nonzero one down.
      if (req_rest[27:21] != 7'd0) begin
         grp_cnt_in = 3'd4;
      end else if (req_rest[20:14] != 7'd0) begin
         grp_cnt_in = 3'd3;
      end else if (req_rest[13:7] != 7'd0) begin
         grp_cnt_in = 3'd2;
      end else if (req_rest[6:0] != 7'd0) begin
         grp_cnt_in = 3'd1;
      end else begin
         grp_cnt_in = 3'd0;
      end

      // Minimal length of the value; a zero value still takes one byte.
      if (req_chan.payload.int_value[31:24] != 8'd0) begin
         hi_len = 3'd4;
      end else if (req_chan.payload.int_value[23:16] != 8'd0) begin
         hi_len = 3'd3;
      end else if (req_chan.payload.int_value[15:8] != 8'd0) begin
         hi_len = 3'd2;
      end else begin
         hi_len = 3'd1;
      end

      if (req_chan.payload.byte_count == 3'd0) begin
         req_len = {1'b0, hi_len};
      end else begin
         req_len = {1'b0, req_chan.payload.byte_count};
      end

      if (req_len > 4'(MAX_INT_BYTES)) begin
         nb_in = NB_MAX;
      end else begin
         nb_in = NB_W'(req_len);
      end
   end

   // ---------------------------------------------------------------------------------------
   // Byte sequencer. The stored item and the byte index select the current byte with a few
   // compares and multiplexers; the index steps each time a byte enters the output register.
   // ---------------------------------------------------------------------------------------
   logic             out_free;
   logic             emit;
   logic             is_last;
   logic [IDX_W-1:0] hdr_len;
   logic [IDX_W-1:0] total_len;
   logic [IDX_W-1:0] val_end;
   logic [IDX_W-1:0] val_pos;
   logic [1:0]       grp_sel;
   logic [2:0]       hdr_type;
   logic [7:0]       hdr_byte;
   logic [7:0]       blob_byte;
   logic [7:0]       val_byte;
   logic [31:0]      val_shift;
   logic [7:0]       cur_byte;

   // Output register state, read by the sequencer to tell whether a byte can move on.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_last_ff, rsp_last_in;

   assign hdr_len = IDX_W'(grp_cnt_ff) + IDX_W'(1);
   // Index one past the last value byte of an integer element.
   assign val_end = hdr_len + IDX_W'(1) + IDX_W'(nb_ff);

   always_comb begin
      unique case (item_ff.command) inside
         CMD_TAG_HDR, CMD_BLOB_HDR: total_len = hdr_len;
         CMD_INT_ELEM:              total_len = val_end + IDX_W'(1);
         default:                   total_len = IDX_W'(1);
      endcase
   end

   assign is_last  = (idx_ff == total_len - IDX_W'(1));
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign emit     = hold_valid_ff && out_free;
   // A new item enters as soon as the current one hands over its last byte.
   assign req_ready = !hold_valid_ff || (emit && is_last);
   assign req_chan.ready = req_ready;

   always_comb begin
      hdr_type = (item_ff.command == CMD_BLOB_HDR) ? blob_type_ff : item_ff.tag_type;
      // Group counted from the low end; only meaningful while idx_ff < grp_cnt_ff.
      grp_sel  = 2'(grp_cnt_ff - 3'd1 - 3'(idx_ff));
      if (idx_ff < IDX_W'(grp_cnt_ff)) begin
         case (grp_sel)
            2'd0:    hdr_byte = {1'b0, item_ff.number[10:4]};
            2'd1:    hdr_byte = {1'b0, item_ff.number[17:11]};
            2'd2:    hdr_byte = {1'b0, item_ff.number[24:18]};
            default: hdr_byte = {1'b0, item_ff.number[31:25]};
         endcase
      end else begin
         hdr_byte = {1'b1, item_ff.number[3:0], hdr_type};
      end

      // The byte count never exceeds MAX_INT_BYTES, so below 16 its blob header is a single byte.
      blob_byte = {1'b1, 4'(nb_ff), blob_type_ff};

      // Value bytes go out big endian; positions above the 32-bit value read as zero.
      val_pos   = val_end - IDX_W'(1) - idx_ff;
      val_shift = item_ff.int_value >> {val_pos[1:0], 3'b000};
      if (val_pos < IDX_W'(4)) begin
         val_byte = val_shift[7:0];
      end else begin
         val_byte = 8'h00;
      end

      unique case (item_ff.command) inside
         CMD_TAG_HDR, CMD_BLOB_HDR: begin
            cur_byte = hdr_byte;
         end
         CMD_DATA: begin
            cur_byte = item_ff.data_byte;
         end
         CMD_INT_ELEM: begin
            if (idx_ff < hdr_len) begin
               cur_byte = hdr_byte;
            end else if (idx_ff == hdr_len) begin
               cur_byte = blob_byte;
            end else if (idx_ff < val_end) begin
               cur_byte = val_byte;
            end else begin
               cur_byte = END_BYTE;
            end
         end
         default: begin
            cur_byte = END_BYTE;
         end
      endcase
   end

   always_comb begin
      hold_valid_in = hold_valid_ff;
      idx_in        = idx_ff;
      item_in       = item_ff;
      if (req_accept) begin
         // Unused command codes are dropped here and never occupy the sequencer.
         hold_valid_in = cmd_known;
         idx_in        = '0;
         item_in       = req_chan.payload;
      end else if (emit) begin
         if (is_last) begin
            hold_valid_in = 1'b0;
         end
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         idx_ff        <= '0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         idx_ff        <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff    <= item_in;
         grp_cnt_ff <= grp_cnt_in;
         nb_ff      <= nb_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Output register. It separates the sequencer from the consumer: while a byte is stalled,
   // a new item can still be taken in while the sequencer is empty, but then it waits there.
   // ---------------------------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_free) begin
         rsp_valid_in = emit;
         rsp_byte_in  = cur_byte;
         rsp_last_in  = is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.payload.out_byte = rsp_byte_ff;
   assign rsp_chan.payload.last     = rsp_last_ff;

   // ---------------------------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------------------------
   `CCNB_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !hold_valid_ff && !rsp_valid_ff, "reset left a stage full")
   `CCNB_ASSERT(a_idx_in_range, clock, reset, hold_valid_ff |-> idx_ff < total_len, "byte index ran past the item")
   `CCNB_ASSERT(a_stall_holds, clock, reset, hold_valid_ff && !out_free |=> hold_valid_ff && $stable(idx_ff), "sequencer moved while the output was stalled")
   `CCNB_ASSERT(a_known_cmd_loads, clock, reset, req_accept && cmd_known |=> hold_valid_ff && idx_ff == '0, "accepted command did not start at its first byte")

endmodule

`default_nettype wire

/* tb/tb_ccnb_element_encoder.sv */
// Self-checking testbench for the CCNb element encoder: directed and random commands.
// Predicts the wire bytes of every accepted item and compares them with the output stream.
// Depends on ccnb_pkg, ccnb_chan_if and ccnb_element_encoder.
`timescale 1ns / 100ps

module tb_ccnb_element_encoder;
   import ccnb_pkg::*;

   localparam int CLK_PERIOD    = 10;
   localparam int RESET_CYCLES  = 5;
   localparam int MAX_INT_BYTES = 4;
   // Settle time after the last expected byte: an item with an unused code may have been
   // taken in and produced nothing, and an integer element holds the sequencer until its bytes are out.
   localparam int SETTLE_CYCLES = 40;
   // Generous bound on the whole run, well above the slowest legal run.
   localparam int CYCLE_LIMIT   = 400000;
   // Length of the long receiver hold-off used to back the block up.
   localparam int HOLD_CYCLES   = 300;
   // Command codes that the block ignores.
   localparam logic [2:0] CMD_SPARE_LO = 3'd5;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_write_enable;
   logic [2:0] csr_write_data;

   ccnb_chan_if #(.payload_type(req_payload_type)) req_if ();
   ccnb_chan_if #(.payload_type(rsp_payload_type)) rsp_if ();

   ccnb_element_encoder #(
      .MAX_INT_BYTES(MAX_INT_BYTES)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Commands waiting to be offered, and wire bytes predicted but not yet seen.
   req_payload_type commands_pending[$];
   rsp_payload_type wire_bytes_due[$];
   rsp_payload_type oldest_due;

   // The testbench's own copy of the blob type register.
   logic [2:0] blob_type_now;

   // Set at a rising edge when the offered command was taken; read by the driver.
   logic req_taken;

   int sender_idle_pct;
   int receiver_stall_pct;
   bit hold_request;
   int hold_left;
   int error_count;
   int cycle_count;

   // ---------------------------------------------------------------------------------
   // Prediction. Each helper appends bytes to the expected stream; the command encoder
   // then marks the final byte of the command, if it produced any.
   // ---------------------------------------------------------------------------------
   function automatic void push_wire_byte(logic [7:0] value);
      rsp_payload_type b;
      b.out_byte = value;
      b.last     = 1'b0;
      wire_bytes_due.push_back(b);
   endfunction

   // A header carries the number's upper 7-bit groups, most significant first, with
   // leading zero groups dropped, then a closing byte with bit 7 set, the low nibble
   // of the number and the 3-bit type.
   function automatic void push_header(logic [31:0] num, logic [2:0] kind);
      logic [27:0] rest;
      logic [6:0]  groups [4];
      int          cnt;
      rest = num[31:4];
      cnt  = 0;
      while (rest != 0) begin
         groups[cnt] = rest[6:0];
         rest        = rest >> 7;
         cnt++;
      end
      while (cnt > 0) begin
         cnt--;
         push_wire_byte({1'b0, groups[cnt]});
      end
      push_wire_byte({1'b1, num[3:0], kind});
   endfunction

   function automatic void encode_command(req_payload_type c);
      int unsigned width;
      int          first;
      first = wire_bytes_due.size();
      case (c.command)
         CMD_TAG_HDR:  push_header(c.number, c.tag_type);
         CMD_BLOB_HDR: push_header(c.number, blob_type_now);
         CMD_DATA:     push_wire_byte(c.data_byte);
         CMD_END:      push_wire_byte(END_BYTE);
         CMD_INT_ELEM: begin
            width = {29'd0, c.byte_count};
            if (width == 0) begin
               // Automatic length: drop leading zero bytes, but keep at least one.
               width = MAX_INT_BYTES - 1;
               while (width > 0 && (c.int_value >> (8 * width)) == 0)
                  width--;
               width++;
            end else if (width > MAX_INT_BYTES) begin
               width = MAX_INT_BYTES;
            end
            push_header(c.number, c.tag_type);
            push_header(width, blob_type_now);
            while (width > 0) begin
               width--;
               push_wire_byte(8'(c.int_value >> (8 * width)));
            end
            push_wire_byte(END_BYTE);
         end
         default: ;  // Unused codes produce nothing.
      endcase
      if (wire_bytes_due.size() > first)
         wire_bytes_due[wire_bytes_due.size() - 1].last = 1'b1;
   endfunction

   // ---------------------------------------------------------------------------------
   // Driver: offers commands at the falling edge. A new command is only put up once the
   // previous one was taken, and the sender may idle between commands.
   // ---------------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (commands_pending.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            req_if.valid   <= 1'b1;
            req_if.payload <= commands_pending.pop_front();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off counted here when it is requested.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   // ---------------------------------------------------------------------------------
   // Monitor: at each rising edge, check an output byte against the oldest prediction,
   // predict the bytes of a command taken at this edge, and follow register writes.
   // The first byte of a command passes through the item and output registers after it is
   // taken, so the order of these steps within the edge does not matter.
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_taken     <= 1'b0;
         blob_type_now = BLOB_TYPE_RESET;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (rsp_if.valid && rsp_if.ready) begin
            if (wire_bytes_due.size() == 0) begin
               $error("unexpected output item: out_byte %h last %b",
                      rsp_if.payload.out_byte, rsp_if.payload.last);
               error_count++;
            end else begin
               oldest_due = wire_bytes_due.pop_front();
               if (rsp_if.payload.out_byte !== oldest_due.out_byte) begin
                  $error("out_byte: expected %h, actual %h",
                         oldest_due.out_byte, rsp_if.payload.out_byte);
                  error_count++;
               end
               if (rsp_if.payload.last !== oldest_due.last) begin
                  $error("last: expected %b, actual %b",
                         oldest_due.last, rsp_if.payload.last);
                  error_count++;
               end
            end
         end
         if (req_if.valid && req_if.ready)
            encode_command(req_if.payload);
         if (csr_write_enable)
            blob_type_now = csr_write_data;
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("ccnb_element_encoder: mismatch");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stimulus helpers.
   // ---------------------------------------------------------------------------------
   function automatic req_payload_type make_command(logic [2:0] cmd, logic [31:0] num,
                                                    logic [2:0] kind, logic [31:0] value,
                                                    logic [2:0] count, logic [7:0] data);
      req_payload_type c;
      c.command    = cmd;
      c.number     = num;
      c.tag_type   = kind;
      c.int_value  = value;
      c.byte_count = count;
      c.data_byte  = data;
      return c;
   endfunction

   // Random command. Integer elements dominate since they exercise the most logic.
   // Numbers and values are shifted by a random amount so that short header and
   // value lengths come up as often as long ones. Unused fields carry noise.
   function automatic req_payload_type random_command();
      logic [2:0] cmd;
      int         pick;
      pick = $urandom_range(0, 99);
      if (pick < 15)       cmd = CMD_TAG_HDR;
      else if (pick < 30)  cmd = CMD_BLOB_HDR;
      else if (pick < 42)  cmd = CMD_DATA;
      else if (pick < 50)  cmd = CMD_END;
      else if (pick < 93)  cmd = CMD_INT_ELEM;
      else                 cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      return make_command(cmd, $urandom >> $urandom_range(0, 31), 3'($urandom),
                          $urandom >> $urandom_range(0, 31), 3'($urandom_range(0, 7)),
                          8'($urandom));
   endfunction

   // Register writes happen only while the block is idle.
   task automatic write_blob_type(logic [2:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Waits until every command is taken and every predicted byte has arrived, then
   // lets the block settle in case the last command produced nothing.
   task automatic wait_drained();
      do
         @(posedge clock);
      while (commands_pending.size() != 0 || req_if.valid || wire_bytes_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_random_phase(logic [2:0] blob_type, int idle_pct, int stall_pct,
                                   int count, bit long_hold);
      write_blob_type(blob_type);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      if (long_hold)
         hold_request = 1'b1;
      repeat (count) commands_pending.push_back(random_command());
      wait_drained();
   endtask

   initial begin
      req_if.valid     = 1'b0;
      req_if.payload   = '0;
      rsp_if.ready     = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_request = 1'b0;
      hold_left    = 0;
      error_count  = 0;
      cycle_count  = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part, with the blob type still at its reset value.
      // Header extremes: zero, a lone low nibble, the first two-byte number, all ones.
      commands_pending.push_back(make_command(CMD_TAG_HDR, 32'd0, 3'd0, '0, '0, '0));
      commands_pending.push_back(make_command(CMD_TAG_HDR, 32'd15, 3'd7, '0, '0, '0));
      commands_pending.push_back(make_command(CMD_TAG_HDR, 32'd16, 3'd2, '1, '1, '1));
      commands_pending.push_back(make_command(CMD_TAG_HDR, 32'hFFFF_FFFF, 3'd7,
                                              '0, '0, '0));
      commands_pending.push_back(make_command(CMD_BLOB_HDR, 32'd0, 3'd3, '0, '0, '0));
      commands_pending.push_back(make_command(CMD_BLOB_HDR, 32'hFFFF_FFFF, 3'd0,
                                              '0, '0, '0));
      // Data bytes at both extremes, and the end marker with noise on unused fields.
      commands_pending.push_back(make_command(CMD_DATA, '1, '1, '1, '1, 8'h00));
      commands_pending.push_back(make_command(CMD_DATA, '0, '0, '0, '0, 8'hFF));
      commands_pending.push_back(make_command(CMD_END, '1, '1, '1, '1, '1));
      // Integer elements: automatic length of a zero value, automatic lengths of one to four
      // bytes, explicit counts one to five and seven, and counts above the maximum clamped.
      commands_pending.push_back(make_command(CMD_INT_ELEM, 32'd0, 3'd0, 32'd0, 3'd0, '0));
      commands_pending.push_back(make_command(CMD_INT_ELEM, 32'd20, 3'd1, 32'hFF,
                                              3'd0, '0));
      commands_pending.push_back(make_command(CMD_INT_ELEM, 32'd300, 3'd6, 32'h100,
                                              3'd0, '0));
      commands_pending.push_back(make_command(CMD_INT_ELEM, 32'd5, 3'd4, 32'h0001_0000,
                                              3'd0, '0));
      commands_pending.push_back(make_command(CMD_INT_ELEM, 32'hFFFF_FFFF, 3'd7,
                                              32'hFFFF_FFFF, 3'd0, '1));
      commands_pending.push_back(make_command(CMD_INT_ELEM, 32'd1, 3'd2, 32'h1234_5678,
                                              3'd1, '0));
      commands_pending.push_back(make_command(CMD_INT_ELEM, 32'd2, 3'd2, 32'h1234_5678,
                                              3'd2, '0));
      commands_pending.push_back(make_command(CMD_INT_ELEM, 32'd3, 3'd2, 32'h0000_0001,
                                              3'd3, '0));
      commands_pending.push_back(make_command(CMD_INT_ELEM, 32'd4, 3'd2, 32'h0000_0000,
                                              3'd4, '0));
      commands_pending.push_back(make_command(CMD_INT_ELEM, 32'd77, 3'd5, 32'hDEAD_BEEF,
                                              3'd5, '0));
      commands_pending.push_back(make_command(CMD_INT_ELEM, 32'd78, 3'd5, 32'h8000_0001,
                                              3'd7, '0));
      // Unused codes, each followed by a real command so a stray byte would show up.
      for (int code = CMD_SPARE_LO; code <= CMD_SPARE_HI; code++) begin
         commands_pending.push_back(make_command(3'(code), '1, '1, '1, '1, '1));
         commands_pending.push_back(make_command(CMD_DATA, '0, '0, '0, '0, 8'(code)));
      end
      wait_drained();

      // Random part, over several blob type settings and handshake patterns. The first
      // phase holds the receiver off for a long stretch while the sender keeps offering
      // commands, so the block fills up and has to stall its input.
      run_random_phase(3'd0, 0, 0, 24, 1'b1);
      run_random_phase(3'd7, 88, 0, 24, 1'b0);
      run_random_phase(3'($urandom), 0, 88, 24, 1'b0);
      run_random_phase(3'($urandom), 21, 21, 24, 1'b0);

      if (error_count == 0) begin
         $display("ccnb_element_encoder: match");
      end else begin
         $display("ccnb_element_encoder: mismatch");
      end
      $finish;
   end

endmodule

/* ccnb_element_encoder.f */
+incdir+sv
sv/ccnb_pkg.sv
sv/ccnb_chan_if.sv
sv/ccnb_element_encoder.sv
tb/tb_ccnb_element_encoder.sv
